// ----- rtl/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types, constants and codes of the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int HEAP_BYTES_DEF   = 4194304;
   localparam int HEADER_BYTES_DEF = 16;
   localparam int ALIGN_BYTES_DEF  = 8;
   localparam int MAX_BLOCKS_DEF   = 64;

   localparam int AW = 22;
   localparam int SW = 23;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOMEM   = 2'd1;
   localparam logic [1:0] ST_BADADDR = 2'd2;

   typedef struct packed {
      logic [AW-1:0] start;
      logic [SW-1:0] size;
      logic          free;
   } entry_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_ROUND,
      OP_SCAN_READ,
      OP_STEP,
      OP_HIT,
      OP_INS_READ,
      OP_INS_WRITE,
      OP_INS_NEW,
      OP_WR_ALLOC,
      OP_NEXT_READ,
      OP_NEXT_LATCH,
      OP_MERGE,
      OP_REM_READ,
      OP_REM_WRITE,
      OP_REM_DONE,
      OP_FAIL,
      OP_POST
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_ROUND,
      S_PREP,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_INS_RD,
      S_INS_WR,
      S_INS_NEW,
      S_WR_ALLOC,
      S_NEXT_RD,
      S_NEXT_LATCH,
      S_MERGE,
      S_REM_RD,
      S_REM_WR,
      S_FAIL,
      S_FIN
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic zero;
      logic hit;
      logic last;
      logic split;
      logic ins_done;
      logic rem_done;
      logic rsp_busy;
   } stat_type;

endpackage

// ----- rtl/ffha_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffha_ctrl
// sequencer: rounding, table walk, insert and remove sweeps, result handoff
// ----------------------------------------------------------------------------
module ffha_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ffha_pkg::stat_type stat,
   output ffha_pkg::cmd_type  cmd
);

   ffha_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffha_pkg::S_IDLE:       if (req_valid) state_in = ffha_pkg::S_DISPATCH;
         ffha_pkg::S_DISPATCH: begin
            priority if (stat.is_free) state_in = ffha_pkg::S_SCAN_RD;
            else if (stat.zero)        state_in = ffha_pkg::S_FAIL;
            else                       state_in = ffha_pkg::S_ROUND;
         end
         ffha_pkg::S_ROUND:      state_in = ffha_pkg::S_PREP;
         ffha_pkg::S_PREP:       state_in = ffha_pkg::S_SCAN_RD;
         ffha_pkg::S_SCAN_RD:    state_in = ffha_pkg::S_SCAN_CHK;
         ffha_pkg::S_SCAN_CHK: begin
            priority if (stat.hit && stat.is_free)
               state_in = stat.last ? ffha_pkg::S_MERGE : ffha_pkg::S_NEXT_RD;
            else if (stat.hit)
               state_in = stat.split ? ffha_pkg::S_INS_RD : ffha_pkg::S_WR_ALLOC;
            else
               state_in = stat.last ? ffha_pkg::S_FAIL : ffha_pkg::S_SCAN_RD;
         end
         ffha_pkg::S_INS_RD:
            state_in = stat.ins_done ? ffha_pkg::S_INS_NEW : ffha_pkg::S_INS_WR;
         ffha_pkg::S_INS_WR:     state_in = ffha_pkg::S_INS_RD;
         ffha_pkg::S_INS_NEW:    state_in = ffha_pkg::S_WR_ALLOC;
         ffha_pkg::S_WR_ALLOC:   state_in = ffha_pkg::S_FIN;
         ffha_pkg::S_NEXT_RD:    state_in = ffha_pkg::S_NEXT_LATCH;
         ffha_pkg::S_NEXT_LATCH: state_in = ffha_pkg::S_MERGE;
         ffha_pkg::S_MERGE:      state_in = ffha_pkg::S_REM_RD;
         ffha_pkg::S_REM_RD:
            state_in = stat.rem_done ? ffha_pkg::S_FIN : ffha_pkg::S_REM_WR;
         ffha_pkg::S_REM_WR:     state_in = ffha_pkg::S_REM_RD;
         ffha_pkg::S_FAIL:       state_in = ffha_pkg::S_FIN;
         ffha_pkg::S_FIN:        if (!stat.rsp_busy) state_in = ffha_pkg::S_IDLE;
         default:                state_in = ffha_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = ffha_pkg::OP_NOP;
      unique case (state_ff)
         ffha_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = ffha_pkg::OP_LOAD;
         end
         ffha_pkg::S_ROUND:      cmd.op = ffha_pkg::OP_ROUND;
         ffha_pkg::S_SCAN_RD:    cmd.op = ffha_pkg::OP_SCAN_READ;
         ffha_pkg::S_SCAN_CHK:   cmd.op = stat.hit ? ffha_pkg::OP_HIT : ffha_pkg::OP_STEP;
         ffha_pkg::S_INS_RD:
            cmd.op = stat.ins_done ? ffha_pkg::OP_NOP : ffha_pkg::OP_INS_READ;
         ffha_pkg::S_INS_WR:     cmd.op = ffha_pkg::OP_INS_WRITE;
         ffha_pkg::S_INS_NEW:    cmd.op = ffha_pkg::OP_INS_NEW;
         ffha_pkg::S_WR_ALLOC:   cmd.op = ffha_pkg::OP_WR_ALLOC;
         ffha_pkg::S_NEXT_RD:    cmd.op = ffha_pkg::OP_NEXT_READ;
         ffha_pkg::S_NEXT_LATCH: cmd.op = ffha_pkg::OP_NEXT_LATCH;
         ffha_pkg::S_MERGE:      cmd.op = ffha_pkg::OP_MERGE;
         ffha_pkg::S_REM_RD:
            cmd.op = stat.rem_done ? ffha_pkg::OP_REM_DONE : ffha_pkg::OP_REM_READ;
         ffha_pkg::S_REM_WR:     cmd.op = ffha_pkg::OP_REM_WRITE;
         ffha_pkg::S_FAIL:       cmd.op = ffha_pkg::OP_FAIL;
         ffha_pkg::S_FIN:        if (!stat.rsp_busy) cmd.op = ffha_pkg::OP_POST;
         default:                cmd.op = ffha_pkg::OP_NOP;
      endcase
   end

endmodule

// ----- rtl/ffha_dp.sv -----
// ----------------------------------------------------------------------------
// ffha_dp
// block table memory, request registers, size rounding and result registers
// ----------------------------------------------------------------------------
module ffha_dp #(
   parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
   parameter int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF,
   parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_action,
   input  logic [ffha_pkg::SW-1:0]   req_size,
   input  logic [ffha_pkg::AW-1:0]   req_block_address,
   input  ffha_pkg::cmd_type         cmd,
   output ffha_pkg::stat_type        stat,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic [ffha_pkg::AW-1:0]   rsp_granted_address
);

   localparam int AW = ffha_pkg::AW;
   localparam int SW = ffha_pkg::SW;
   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   // reciprocal shift: dividend below 2^(SW+1), alignment up to 64
   localparam int RS = SW + 7;
   localparam int PW = SW + 1 + RS + 1;

   localparam longint RECIP_L =
      ((longint'(1) << RS) + longint'(ALIGN_BYTES) - longint'(1)) / longint'(ALIGN_BYTES);
   localparam logic [RS:0]   RECIP   = (RS + 1)'(RECIP_L);
   localparam logic [SW+1:0] THR_ADD = (SW + 2)'(HEADER_BYTES + ALIGN_BYTES);
   localparam logic [SW:0]   HDR_R   = (SW + 1)'(HEADER_BYTES);
   localparam logic [SW-1:0] HDR_S   = SW'(HEADER_BYTES);
   localparam logic [SW-1:0] HDR2_S  = SW'(2 * HEADER_BYTES);
   localparam logic [AW-1:0] HDR_A   = AW'(HEADER_BYTES);
   localparam logic [SW:0]   ALN_S   = (SW + 1)'(ALIGN_BYTES);
   localparam logic [SW:0]   ALN_M1  = (SW + 1)'(ALIGN_BYTES - 1);
   localparam logic [CW-1:0] MAX_C   = CW'(MAX_BLOCKS);
   localparam ffha_pkg::entry_type RESET_ENTRY =
      '{start: '0, size: SW'(HEAP_BYTES - HEADER_BYTES), free: 1'b1};

   ffha_pkg::entry_type mem [MAX_BLOCKS];
   ffha_pkg::entry_type rd_ff, cur, wr_data;
   logic                wr_en;
   logic [IW-1:0]       wr_addr, rd_addr;

   logic          action_ff, action_in;
   logic [SW-1:0] size_ff, size_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [SW:0]   quo_ff, quo_in;
   logic [SW:0]   rsize_ff, rsize_in;
   logic [SW+1:0] thr_ff, thr_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] hit_ff, hit_in;
   logic [CW-1:0] k_ff, k_in;
   logic [1:0]    d_ff, d_in;
   logic          split_ff, split_in;
   logic          nxt_ok_ff, nxt_ok_in;
   logic          init_ff, init_in;
   logic          rd_init_ff, rd_init_in;
   ffha_pkg::entry_type prev_ff, prev_in, hent_ff, hent_in, nxt_ff, nxt_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [AW-1:0] res_granted_ff, res_granted_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [AW-1:0] rsp_granted_ff, rsp_granted_in;

   logic [SW:0]   rnd_x;
   logic [PW-1:0] prod;
   logic          cur_hit, split_now, pm, nm;
   logic [CW-1:0] hit_p1, hit_m1, k_m1;
   logic [CW:0]   k_pd;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   assign cur     = rd_init_ff ? RESET_ENTRY : rd_ff;
   // round up by reciprocal multiply: quotient of size + align - 1
   assign rnd_x   = {1'b0, size_ff} + ALN_M1;
   assign prod    = PW'(rnd_x) * PW'(RECIP);
   assign hit_p1  = hit_ff + CW'(1);
   assign hit_m1  = hit_ff - CW'(1);
   assign k_m1    = k_ff - CW'(1);
   assign k_pd    = {1'b0, k_ff} + (CW + 1)'(d_ff);

   assign cur_hit = action_ff
      ? (!cur.free && (({1'b0, cur.start} + HDR_R[AW:0]) == {1'b0, addr_ff}))
      : (cur.free && ({1'b0, cur.size} >= rsize_ff));
   assign split_now = ({2'b00, cur.size} >= thr_ff) && (cnt_ff < MAX_C);
   assign pm = (hit_ff != '0) && prev_ff.free;
   assign nm = nxt_ok_ff && nxt_ff.free;

   always_comb begin
      action_in      = action_ff;
      size_in        = size_ff;
      addr_in        = addr_ff;
      quo_in         = quo_ff;
      rsize_in       = quo_ff * ALN_S;
      thr_in         = {1'b0, rsize_ff} + THR_ADD;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      hit_in         = hit_ff;
      k_in           = k_ff;
      d_in           = d_ff;
      split_in       = split_ff;
      nxt_ok_in      = nxt_ok_ff;
      prev_in        = prev_ff;
      hent_in        = hent_ff;
      nxt_in         = nxt_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = cur;
      rd_addr        = '0;
      unique case (cmd.op)
         ffha_pkg::OP_LOAD: begin
            action_in = req_action;
            size_in   = req_size;
            addr_in   = req_block_address;
            idx_in    = '0;
         end
         ffha_pkg::OP_ROUND: quo_in = prod[RS +: SW + 1];
         ffha_pkg::OP_SCAN_READ: rd_addr = idx_ff[IW-1:0];
         ffha_pkg::OP_STEP: begin
            prev_in = cur;
            idx_in  = idx_ff + CW'(1);
         end
         ffha_pkg::OP_HIT: begin
            hit_in    = idx_ff;
            hent_in   = cur;
            split_in  = split_now;
            k_in      = cnt_ff;
            nxt_ok_in = 1'b0;
         end
         ffha_pkg::OP_INS_READ: rd_addr = k_m1[IW-1:0];
         ffha_pkg::OP_INS_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = k_ff[IW-1:0];
            wr_data = cur;
            k_in    = k_m1;
         end
         ffha_pkg::OP_INS_NEW: begin
            wr_en         = 1'b1;
            wr_addr       = hit_p1[IW-1:0];
            wr_data.start = hent_ff.start + HDR_A + rsize_ff[AW-1:0];
            wr_data.size  = hent_ff.size - rsize_ff[SW-1:0] - HDR_S;
            wr_data.free  = 1'b1;
            cnt_in        = cnt_ff + CW'(1);
         end
         ffha_pkg::OP_WR_ALLOC: begin
            wr_en          = 1'b1;
            wr_addr        = hit_ff[IW-1:0];
            wr_data.start  = hent_ff.start;
            wr_data.size   = split_ff ? rsize_ff[SW-1:0] : hent_ff.size;
            wr_data.free   = 1'b0;
            res_status_in  = ffha_pkg::ST_OK;
            res_granted_in = hent_ff.start + HDR_A;
         end
         ffha_pkg::OP_NEXT_READ: rd_addr = hit_p1[IW-1:0];
         ffha_pkg::OP_NEXT_LATCH: begin
            nxt_in    = cur;
            nxt_ok_in = 1'b1;
         end
         ffha_pkg::OP_MERGE: begin
            wr_en        = 1'b1;
            wr_data.free = 1'b1;
            priority if (pm && nm) begin
               wr_addr       = hit_m1[IW-1:0];
               wr_data.start = prev_ff.start;
               wr_data.size  = prev_ff.size + HDR2_S + hent_ff.size + nxt_ff.size;
               k_in          = hit_ff;
               d_in          = 2'd2;
            end else if (pm) begin
               wr_addr       = hit_m1[IW-1:0];
               wr_data.start = prev_ff.start;
               wr_data.size  = prev_ff.size + HDR_S + hent_ff.size;
               k_in          = hit_ff;
               d_in          = 2'd1;
            end else if (nm) begin
               wr_addr       = hit_ff[IW-1:0];
               wr_data.start = hent_ff.start;
               wr_data.size  = hent_ff.size + HDR_S + nxt_ff.size;
               k_in          = hit_p1;
               d_in          = 2'd1;
            end else begin
               wr_addr       = hit_ff[IW-1:0];
               wr_data.start = hent_ff.start;
               wr_data.size  = hent_ff.size;
               k_in          = cnt_ff;
               d_in          = 2'd0;
            end
         end
         ffha_pkg::OP_REM_READ: rd_addr = k_pd[IW-1:0];
         ffha_pkg::OP_REM_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = k_ff[IW-1:0];
            wr_data = cur;
            k_in    = k_ff + CW'(1);
         end
         ffha_pkg::OP_REM_DONE: begin
            cnt_in         = cnt_ff - CW'(d_ff);
            res_status_in  = ffha_pkg::ST_OK;
            res_granted_in = '0;
         end
         ffha_pkg::OP_FAIL: begin
            res_status_in  = action_ff ? ffha_pkg::ST_BADADDR : ffha_pkg::ST_NOMEM;
            res_granted_in = '0;
         end
         ffha_pkg::OP_POST: begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = res_status_ff;
            rsp_granted_in = res_granted_ff;
         end
         default: ;
      endcase
      init_in    = init_ff && !(wr_en && (wr_addr == '0));
      rd_init_in = init_ff && (rd_addr == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= CW'(1);
         init_ff      <= 1'b1;
         rd_init_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         init_ff      <= init_in;
         rd_init_ff   <= rd_init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff      <= action_in;
      size_ff        <= size_in;
      addr_ff        <= addr_in;
      quo_ff         <= quo_in;
      rsize_ff       <= rsize_in;
      thr_ff         <= thr_in;
      idx_ff         <= idx_in;
      hit_ff         <= hit_in;
      k_ff           <= k_in;
      d_ff           <= d_in;
      split_ff       <= split_in;
      nxt_ok_ff      <= nxt_ok_in;
      prev_ff        <= prev_in;
      hent_ff        <= hent_in;
      nxt_ff         <= nxt_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
   end

   assign stat.is_free    = action_ff;
   assign stat.zero       = (size_ff == '0);
   assign stat.hit        = cur_hit;
   assign stat.last       = ({1'b0, idx_ff} + (CW + 1)'(1)) >= {1'b0, cnt_ff};
   assign stat.split      = split_now;
   assign stat.ins_done   = (k_ff == hit_p1);
   assign stat.rem_done   = (k_pd >= {1'b0, cnt_ff});
   assign stat.rsp_busy   = rsp_valid_ff;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_granted_ff;

endmodule

// ----- rtl/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit allocator over an address-ordered block table, with split on
// allocate and merge of free neighbors on release
// ----------------------------------------------------------------------------
//   channel | ports                                              | dir
//   req     | req_valid req_ready req_action req_size             | in
//           | req_block_address                                   |
//   rsp     | rsp_valid rsp_ready rsp_status rsp_granted_address  | out
//
// one request at a time; each one walks the table one entry at a time, with a
// read state and a check state per entry, through the table memory with one
// read and one write port; a release also reads the next entry when one exists,
// and entries move one by one, with a read and a write state each, when a split
// inserts or a merge removes entries; a miss walks every entry; the next
// transfer is taken once the sequencer is back in its idle state
// synchronous reset leaves one free block; the table needs no clearing pass
// a result waiting on rsp_ready holds the next request in the final state
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
   parameter int ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF,
   parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_action,
   input  logic [ffha_pkg::SW-1:0] req_size,
   input  logic [ffha_pkg::AW-1:0] req_block_address,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [ffha_pkg::AW-1:0] rsp_granted_address
);

   ffha_pkg::cmd_type  cmd;
   ffha_pkg::stat_type stat;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffha_dp #(
      .HEAP_BYTES   (HEAP_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .ALIGN_BYTES  (ALIGN_BYTES),
      .MAX_BLOCKS   (MAX_BLOCKS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_action          (req_action),
      .req_size            (req_size),
      .req_block_address   (req_block_address),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address)
   );

endmodule

// ----- tb/first_fit_heap_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// drives allocate and release requests into the heap allocator and compares
// every response against a behavioral block-table model kept in the bench
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;

   localparam int SW     = ffha_pkg::SW;
   localparam int AW     = ffha_pkg::AW;
   localparam int HEAP   = ffha_pkg::HEAP_BYTES_DEF;
   localparam int HDR    = ffha_pkg::HEADER_BYTES_DEF;
   localparam int ALGN   = ffha_pkg::ALIGN_BYTES_DEF;
   localparam int NBLK   = ffha_pkg::MAX_BLOCKS_DEF;
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;
   localparam longint CYCLE_LIMIT = 4000000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic          req_action = 1'b0;
   logic [SW-1:0] req_size = '0;
   logic [AW-1:0] req_block_address = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [1:0]    rsp_status;
   logic [AW-1:0] rsp_granted_address;

   first_fit_heap_allocator dut (.*);

   always #5 clock = ~clock;

   // model of the block table
   longint blk_start [NBLK];
   longint blk_size  [NBLK];
   bit     blk_free  [NBLK];
   int     blk_count;

   typedef struct packed {
      logic [1:0]    status;
      logic [AW-1:0] addr;
   } answer_type;

   answer_type    pending_answers[$];
   logic [AW-1:0] live_addrs[$];
   int        errors = 0;
   longint    cycles = 0;
   int        n_sent = 0, n_ok = 0, n_nomem = 0, n_bad = 0;
   bit        rsp_stall_on = 1'b1;

   task automatic table_reset();
      blk_start[0] = 0;
      blk_size[0] = HEAP - HDR;
      blk_free[0] = 1'b1;
      blk_count = 1;
   endtask

   function automatic answer_type model_allocate(longint req);
      answer_type a;
      longint rs;
      a.status = ffha_pkg::ST_NOMEM;
      a.addr = '0;
      if (req == 0) return a;
      rs = ((req + ALGN - 1) / ALGN) * ALGN;
      for (int i = 0; i < blk_count; i++) begin
         if (blk_free[i] && blk_size[i] >= rs) begin
            if (blk_size[i] >= rs + HDR + ALGN && blk_count < NBLK) begin
               for (int k = blk_count; k > i + 1; k--) begin
                  blk_start[k] = blk_start[k-1];
                  blk_size[k] = blk_size[k-1];
                  blk_free[k] = blk_free[k-1];
               end
               blk_start[i+1] = blk_start[i] + HDR + rs;
               blk_size[i+1] = blk_size[i] - rs - HDR;
               blk_free[i+1] = 1'b1;
               blk_count++;
               blk_size[i] = rs;
            end
            blk_free[i] = 1'b0;
            a.status = ffha_pkg::ST_OK;
            a.addr = AW'(blk_start[i] + HDR);
            return a;
         end
      end
      return a;
   endfunction

   function automatic answer_type model_release(longint addr);
      answer_type a;
      int j;
      a.status = ffha_pkg::ST_BADADDR;
      a.addr = '0;
      for (int i = 0; i < blk_count; i++) begin
         if (!blk_free[i] && blk_start[i] + HDR == addr) begin
            blk_free[i] = 1'b1;
            j = 0;
            while (j + 1 < blk_count) begin
               if (blk_free[j] && blk_free[j+1]) begin
                  blk_size[j] += HDR + blk_size[j+1];
                  for (int k = j + 1; k + 1 < blk_count; k++) begin
                     blk_start[k] = blk_start[k+1];
                     blk_size[k] = blk_size[k+1];
                     blk_free[k] = blk_free[k+1];
                  end
                  blk_count--;
               end else begin
                  j++;
               end
            end
            a.status = ffha_pkg::ST_OK;
            return a;
         end
      end
      return a;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_request(logic act, logic [SW-1:0] sz, logic [AW-1:0] addr);
      answer_type a;
      int g;
      int found;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_size <= sz;
      req_block_address <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (act == ACT_ALLOC) begin
         a = model_allocate(sz);
         if (a.status == ffha_pkg::ST_OK) live_addrs.push_back(a.addr);
      end else begin
         a = model_release(addr);
         if (a.status == ffha_pkg::ST_OK) begin
            found = -1;
            for (int i = 0; i < live_addrs.size(); i++)
               if (found < 0 && live_addrs[i] == addr) found = i;
            if (found >= 0) live_addrs.delete(found);
         end
      end
      pending_answers.push_back(a);
      n_sent++;
   endtask

   task automatic drain_answers();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // response stall generator
   always @(posedge clock) begin
      if (reset || !rsp_stall_on) begin
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 30) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected response status=%0d addr=%0h", $time,
                     rsp_status, rsp_granted_address);
            errors++;
         end else begin
            e = pending_answers.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_granted_address !== e.addr) begin
               $display("%0t: granted_address expected %0h actual %0h", $time, e.addr,
                        rsp_granted_address);
               errors++;
            end
            case (e.status)
               ffha_pkg::ST_OK: n_ok++;
               ffha_pkg::ST_NOMEM: n_nomem++;
               default: n_bad++;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [AW-1:0] pick_live();
      if (live_addrs.size() == 0) return AW'(HDR);
      return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
   endfunction

   task automatic test_edges();
      send_request(ACT_ALLOC, '0, '0);
      send_request(ACT_FREE, '0, '0);
      send_request(ACT_FREE, '0, AW'(HDR));
      send_request(ACT_ALLOC, SW'(1), '1);
      send_request(ACT_ALLOC, SW'(8), '0);
      send_request(ACT_ALLOC, SW'(9), '0);
      send_request(ACT_FREE, '0, AW'(HDR + 4));
      send_request(ACT_FREE, '0, AW'(HDR + 8 + HDR));
      send_request(ACT_FREE, '0, AW'(HDR + 8 + HDR));
      send_request(ACT_FREE, '0, '1);
      send_request(ACT_ALLOC, 23'h7FFFFF, '0);
      send_request(ACT_ALLOC, SW'(HEAP), '0);
      send_request(ACT_ALLOC, SW'(HEAP - 3 * HDR - 16), '0);
      send_request(ACT_ALLOC, SW'(8), '0);
      send_request(ACT_FREE, '0, AW'(HDR));
      while (live_addrs.size() != 0) send_request(ACT_FREE, '0, live_addrs[0]);
      send_request(ACT_ALLOC, SW'(HEAP - HDR), '0);
      send_request(ACT_FREE, '0, AW'(HDR));
      drain_answers();
   endtask

   task automatic test_table_full();
      // fill the table so the last grant takes the remainder without a split
      for (int i = 0; i < NBLK + 2; i++)
         send_request(ACT_ALLOC, SW'($urandom_range(1, 64)), '0);
      send_request(ACT_ALLOC, SW'(100), '0);
      for (int i = 0; i < 20; i++) send_request(ACT_FREE, '0, pick_live());
      drain_answers();
   endtask

   task automatic test_random(int n);
      int r;
      logic [SW-1:0] sz;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            case ($urandom_range(0, 9))
               0: sz = SW'($urandom());
               1: sz = SW'($urandom_range(0, 23'h7FFFFF));
               2, 3: sz = SW'($urandom_range(1, 65536));
               default: sz = SW'($urandom_range(0, 200));
            endcase
            send_request(ACT_ALLOC, sz, AW'($urandom()));
         end else if (r < 85) begin
            send_request(ACT_FREE, SW'($urandom()), pick_live());
         end else if (r < 92) begin
            send_request(ACT_FREE, SW'($urandom()), AW'($urandom()));
         end else begin
            send_request(ACT_FREE, SW'($urandom()), pick_live() + AW'($urandom_range(1, 8)));
         end
         if (i == n / 2) begin
            drain_answers();
            rsp_stall_on = 1'b0;
         end
         if (i == (3 * n) / 4) rsp_stall_on = 1'b1;
      end
      drain_answers();
   endtask

   initial begin
      table_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edges();
      test_table_full();
      test_random(1900);
      $display("sent %0d requests: %0d ok, %0d out of memory, %0d bad address",
               n_sent, n_ok, n_nomem, n_bad);
      $display("covered zero size, oversize, table full, merges and random churn");
      if (errors == 0 && pending_answers.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
